// ----- hdl/sscs_pkg.sv -----
// Shared types and constants of the sieve stride command splitter.
package sscs_pkg;

  localparam int RESULT_CAP = 32;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_PES   = 2'd1;
  localparam logic [1:0] REG_MAXV  = 2'd2;

  // Classified request handed from the front to the back part.
  typedef struct packed {
    logic [15:0] prime;
    logic        finished;
    logic [31:0] idx;
  } job_t;

  // One result item.
  typedef struct packed {
    logic [4:0]  pe_index;
    logic [13:0] seg_offset;
    logic [15:0] stride;
    logic        finished;
    logic        last;
    logic [31:0] command_total;
  } cmd_t;

endpackage

// ----- hdl/sscs_front.sv -----
// Front part: accept a prime, square it, and classify the request.
module sscs_front
  import sscs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] prime,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [34:0] lim,
  output job_t        job,
  output logic        job_valid,
  input  logic        job_ready
);

  logic        busy;
  logic [15:0] p;
  logic [31:0] sq;

  assign in_ready  = !busy;
  assign job_valid = busy;
  assign job.prime    = p;
  assign job.finished = ({3'd0, sq} > lim);
  assign job.idx      = {1'b0, sq[31:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
    end else if (job_ready) begin
      busy <= 1'b0;
    end
    if (in_valid && in_ready) begin
      p  <= prime;
      sq <= prime * prime;
    end
  end

endmodule

// ----- hdl/sscs_back.sv -----
// Back part: walk the segments of one prime and issue marking commands.
module sscs_back
  import sscs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clr,
  input  job_t        job,
  input  logic        job_valid,
  output logic        job_ready,
  input  logic [9:0]  rows,
  input  logic [6:0]  pes,
  input  logic [34:0] lim,
  output cmd_t        cmd,
  output logic        cmd_valid,
  input  logic        cmd_ready
);

  localparam logic [2:0] S_IDLE = 3'd0, S_SEG = 3'd1, S_DIV = 3'd2, S_STEP = 3'd3,
                         S_OUT = 3'd4;

  logic [2:0]  state;
  logic [15:0] p;
  logic [33:0] idx;
  logic [33:0] rem;      // remainder / walk scratch
  logic [4:0]  pe;       // segment number of the pending command
  logic [33:0] quo;
  logic [5:0]  cnt;      // bit counter of the serial divider
  logic [5:0]  n;
  logic [31:0] counter;
  logic [14:0] seg;
  logic [13:0] off;
  logic        phase;    // 0: idx/seg, 1: (seg-1-off)/p
  logic [33:0] den;
  logic [34:0] trial;
  logic [15:0] cells;    // PEs in use times rows per PE
  logic [33:0] span;     // first bit index past the last PE in use
  logic [15:0] steps;
  logic [31:0] jump;
  logic        stop;
  logic        send;     // a marking command leaves S_OUT this cycle
  logic        done_now; // a finished result is taken on this cycle

  assign seg   = {rows, 5'd0};
  assign den   = phase ? {18'd0, p} : {19'd0, seg};
  assign trial = {rem[33:0], quo[33]} - {1'b0, den};
  assign job_ready = (state == S_IDLE) && !cmd_valid;

  assign cells = {9'd0, pes} * {6'd0, rows};
  assign span  = {13'd0, cells, 5'd0};
  assign steps = {1'b0, quo[14:0]} + 16'd1;
  assign jump  = {16'd0, steps} * {16'd0, p};
  // stop after this command: stride zero, cap reached, past the limit or past the PEs
  assign stop  = (p == 16'd0) || (n == 6'(RESULT_CAP - 1)) ||
                 ({rem, 1'b1} > lim) || (rem >= span);
  assign send     = (state == S_OUT) && (!cmd_valid || cmd_ready);
  assign done_now = job_valid && job_ready && job.finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd_valid <= 1'b0;
      counter <= 32'd0;
    end else begin
      if (clr) counter <= 32'd0;
      else if (send) counter <= counter + 32'd1;
      if (done_now || send) cmd_valid <= 1'b1;
      else if (cmd_ready) cmd_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            p <= job.prime;
            idx <= {2'd0, job.idx};
            n <= 6'd0;
            if (job.finished) begin
              cmd <= '{5'd0, 14'd0, 16'd0, 1'b1, 1'b1, counter};
            end else begin
              phase <= 1'b0; rem <= '0; quo <= {2'd0, job.idx}; cnt <= 6'd34;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (trial[34]) begin
            rem <= {rem[32:0], quo[33]};
            quo <= {quo[32:0], 1'b0};
          end else begin
            rem <= trial[33:0];
            quo <= {quo[32:0], 1'b1};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= S_SEG;
        end
        S_SEG: begin
          if (!phase) begin
            pe  <= quo[4:0];
            off <= rem[13:0];
            if ((quo >= {27'd0, pes}) && n == 6'd0) begin
              state <= S_IDLE;       // first segment beyond the PEs: no result
            end else if (p == 16'd0) begin
              state <= S_OUT; idx <= idx;
              rem <= 34'd0;
            end else begin
              phase <= 1'b1;
              quo <= {19'd0, seg - 15'd1 - rem[14:0]};
              rem <= '0; cnt <= 6'd34;
              state <= S_DIV;
            end
          end else begin
            rem <= idx + {2'd0, jump};  // next index
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (send) begin
            cmd <= '{pe, off, p, 1'b0, stop, counter + 32'd1};
            n <= n + 6'd1;
            if (stop) begin
              state <= S_IDLE;
            end else begin
              idx <= rem; phase <= 1'b0; quo <= rem; rem <= '0; cnt <= 6'd34;
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          state <= S_DIV;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/sieve_stride_command_splitter_unit.sv -----
// Top level of the sieve stride command splitter.
//  channel | dir | fields
//  s_axis  | in  | prime
//  m_axis  | out | pe_index, seg_offset, stride, finished, last, command_total
//  apb     | in  | rows_per_pe, pe_count, max_value
// A marking command is set by two 34-step serial divisions
// (segment number, then steps to the segment end); up to 32 commands per prime.
// A finished prime is answered on the cycle after the back part takes it.
// Reset is synchronous; a stall on either side holds the queue.
module sieve_stride_command_splitter_unit
  import sscs_pkg::*;
#(
  parameter int MAX_PE = 32,
  parameter int MAX_ROWS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // prime
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // pe_index, seg_offset, stride, command_total
  output logic        m_axis_tlast,   // last
  output logic        m_axis_tuser,   // finished
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [9:0]  rows_per_pe;
  logic [5:0]  pe_count;
  logic [19:0] max_value;
  logic [9:0]  rows;
  logic [6:0]  pes;
  logic [15:0] cells;
  logic [34:0] lim;
  logic        wr, clr;
  job_t        job;
  logic        job_valid, job_ready;
  cmd_t        cmd;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign clr = wr && (paddr[3:2] == REG_ROWS || paddr[3:2] == REG_PES ||
                      paddr[3:2] == REG_MAXV);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_per_pe <= 10'd512; pe_count <= 6'd32; max_value <= 20'hFFFFF;
    end else if (clr) begin
      unique case (paddr[3:2])
        REG_ROWS: rows_per_pe <= pwdata[9:0];
        REG_PES:  pe_count <= pwdata[5:0];
        default:  max_value <= pwdata[19:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS: prdata = {22'd0, rows_per_pe};
      REG_PES:  prdata = {26'd0, pe_count};
      REG_MAXV: prdata = {12'd0, max_value};
      default:  prdata = 32'd0;
    endcase
  end

  // clamp registers
  assign rows = (rows_per_pe == 10'd0) ? 10'd1 :
                ({22'd0, rows_per_pe} > MAX_ROWS) ? 10'(MAX_ROWS) : rows_per_pe;
  assign pes  = (pe_count == 6'd0) ? 7'd1 :
                ({26'd0, pe_count} > MAX_PE) ? 7'(MAX_PE) : {1'b0, pe_count};
  assign cells = {9'd0, pes} * {6'd0, rows};
  assign lim  = (max_value != 20'd0) ? {15'd0, max_value} :
                {13'd0, cells, 6'd0} - 35'd1;

  sscs_front u_front (.clk, .rst, .prime(s_axis_tdata), .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready), .lim, .job, .job_valid, .job_ready);

  sscs_back u_back (.clk, .rst, .clr, .job, .job_valid, .job_ready,
    .rows, .pes, .lim, .cmd, .cmd_valid(m_axis_tvalid), .cmd_ready(m_axis_tready));

  assign m_axis_tdata = {5'd0, cmd.command_total, cmd.stride, cmd.seg_offset,
                         cmd.pe_index};
  assign m_axis_tlast = cmd.last;
  assign m_axis_tuser = cmd.finished;

endmodule

// ----- hdl/sscs_checker.sv -----
// Port-level checker for the splitter, bound to the top level.
module sscs_checker (
  input logic clk,
  input logic rst,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic m_axis_tuser,
  input logic pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast) else $error("finished not last");
  a_ready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind sieve_stride_command_splitter_unit sscs_checker u_chk (.clk, .rst, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tlast, .m_axis_tuser, .pready);
